[design/sol_pkg.sv]
package sol_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W = 48;
    localparam int SEGNUM_W = 9;
    localparam int STATUS_W = 2;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int SIZE_BITS_DEF = 48;
    localparam int TOTAL_BITS_DEF = 56;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } state_t;

endpackage

[design/segment_offset_locator_unit.sv]
// channel  | handshake            | ports
// ---------+----------------------+---------------------------------------------
// command  | start & !busy        | opcode, operand_value
// result   | done (one cycle)     | segment_number, offset_in_segment, status
//
// append, clear, the unused code and a query that needs no search give their word
// in the cycle after acceptance; a query that searches gives it when the binary
// search ends: the search does one read of the totals memory per cycle (one
// read port, registered read data).
// reset clears the segment count and the control; the memory holds no reset value.
// busy stays high while a search runs; the receiver cannot stall the result.
module segment_offset_locator_unit #(
    parameter int MAX_SEGMENTS = sol_pkg::MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS = sol_pkg::SIZE_BITS_DEF,
    parameter int TOTAL_BITS = sol_pkg::TOTAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sol_pkg::OPCODE_W-1:0]  opcode,
    input  logic [sol_pkg::VALUE_W-1:0]   operand_value,
    output logic                          done,
    output logic [sol_pkg::SEGNUM_W-1:0]  segment_number,
    output logic [sol_pkg::VALUE_W-1:0]   offset_in_segment,
    output logic [sol_pkg::STATUS_W-1:0]  status
);

    localparam int VW = sol_pkg::VALUE_W;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SEGW = (CW > sol_pkg::SEGNUM_W) ? CW : sol_pkg::SEGNUM_W;
    localparam int CMPW = (TOTAL_BITS > VW) ? TOTAL_BITS : VW;
    localparam int SUMW = CMPW + 1;
    localparam int SZ_EFF = (SIZE_BITS < VW) ? SIZE_BITS : VW;
    localparam logic [VW-1:0] SIZE_MASK = (VW'(1) << SZ_EFF) - VW'(1);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SEGMENTS);

    logic [TOTAL_BITS-1:0] mem [MAX_SEGMENTS];

    sol_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TOTAL_BITS-1:0] last_total_reg, last_total_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [TOTAL_BITS-1:0] before_reg, before_next;
    logic [VW-1:0] pos_reg, pos_next;
    logic done_reg, done_next;
    logic [sol_pkg::SEGNUM_W-1:0] seg_reg, seg_next;
    logic [VW-1:0] ofs_reg, ofs_next;
    logic [sol_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [TOTAL_BITS-1:0] rd_data_reg;

    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [TOTAL_BITS-1:0] wr_data;

    logic accept;
    logic [TOTAL_BITS-1:0] prev_total;
    logic [SUMW-1:0] sum;
    logic [CMPW-1:0] pos_in_ext;
    logic [CMPW-1:0] pos_reg_ext;
    logic found_ge;
    logic [AW-1:0] lo_step, hi_step;
    logic [TOTAL_BITS-1:0] before_step;
    logic [CMPW-1:0] ofs_wide;

    assign busy = (state_reg != sol_pkg::S_IDLE);
    assign accept = start && !busy;
    assign done = done_reg;
    assign segment_number = seg_reg;
    assign offset_in_segment = ofs_reg;
    assign status = status_reg;

    assign prev_total = (count_reg == '0) ? '0 : last_total_reg;
    assign sum = SUMW'(prev_total) + SUMW'(operand_value & SIZE_MASK);
    assign pos_in_ext = CMPW'(operand_value);
    assign pos_reg_ext = CMPW'(pos_reg);
    assign found_ge = CMPW'(rd_data_reg) >= pos_reg_ext;
    assign lo_step = found_ge ? lo_reg : mid_reg + AW'(1);
    assign hi_step = found_ge ? mid_reg : hi_reg;
    assign before_step = found_ge ? before_reg : rd_data_reg;
    assign ofs_wide = pos_reg_ext - CMPW'(before_step);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        last_total_next = last_total_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        before_next = before_reg;
        pos_next = pos_reg;
        done_next = 1'b0;
        seg_next = seg_reg;
        ofs_next = ofs_reg;
        status_next = status_reg;
        rd_en = 1'b0;
        rd_addr = mid_reg;
        wr_en = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = TOTAL_MAX;

        unique case (state_reg)
            sol_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    ofs_next = '0;
                    status_next = sol_pkg::ST_OK;
                    seg_next = sol_pkg::SEGNUM_W'(SEGW'(count_reg));
                    unique case (opcode)
                        sol_pkg::OP_APPEND:
                        begin
                            if (count_reg == COUNT_FULL)
                            begin
                                status_next = sol_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (sum > SUMW'(TOTAL_MAX))
                                begin
                                    wr_data = TOTAL_MAX;
                                    status_next = sol_pkg::ST_SAT;
                                end
                                else
                                begin
                                    wr_data = sum[TOTAL_BITS-1:0];
                                end
                                last_total_next = wr_data;
                                count_next = count_reg + CW'(1);
                                seg_next = sol_pkg::SEGNUM_W'(SEGW'(count_next));
                            end
                        end
                        sol_pkg::OP_QUERY:
                        begin
                            pos_next = operand_value;
                            before_next = '0;
                            lo_next = '0;
                            hi_next = AW'(count_reg - CW'(1));
                            mid_next = hi_next >> 1;
                            if (operand_value == '0 || count_reg == '0 ||
                                pos_in_ext > CMPW'(last_total_reg))
                            begin
                                status_next = sol_pkg::ST_RANGE;
                                seg_next = '0;
                            end
                            else if (hi_next == '0)
                            begin
                                seg_next = sol_pkg::SEGNUM_W'(1);
                                ofs_next = operand_value;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                rd_en = 1'b1;
                                rd_addr = mid_next;
                                state_next = sol_pkg::S_SEARCH;
                            end
                        end
                        sol_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            seg_next = '0;
                        end
                        default:
                        begin
                            seg_next = sol_pkg::SEGNUM_W'(SEGW'(count_reg));
                        end
                    endcase
                end
            end
            sol_pkg::S_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                before_next = before_step;
                mid_next = lo_step + ((hi_step - lo_step) >> 1);
                if (lo_step == hi_step)
                begin
                    done_next = 1'b1;
                    status_next = sol_pkg::ST_OK;
                    seg_next = sol_pkg::SEGNUM_W'(SEGW'(lo_step) + SEGW'(1));
                    ofs_next = ofs_wide[VW-1:0];
                    state_next = sol_pkg::S_IDLE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = mid_next;
                end
            end
            default:
            begin
                state_next = sol_pkg::S_IDLE;
            end
        endcase
    end

    // totals memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sol_pkg::S_IDLE;
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_total_reg <= last_total_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        before_reg <= before_next;
        pos_reg <= pos_next;
        seg_reg <= seg_next;
        ofs_reg <= ofs_next;
        status_reg <= status_next;
    end

endmodule
